// ===== rtl/awwt_pkg.sv =====
// shared types and codes for the address wait/wake table
package awwt_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_WAIT     = 2'd0,
        ACT_WAKE     = 2'd1,
        ACT_WITHDRAW = 2'd2,
        ACT_OTHER    = 2'd3
    } action_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_DONE        = 3'd0,
        ST_FAULT       = 3'd1,
        ST_AGAIN       = 3'd2,
        ST_INVALID     = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_FULL        = 3'd5,
        ST_WITHDRAWN   = 3'd6
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SCAN  = 2'd1,
        FSM_FINAL = 2'd2
    } state_t;

    // one waiter as stored in the table memory
    typedef struct packed {
        logic [7:0]  space;
        logic [31:0] addr;
        logic [7:0]  task_id;
    } entry_t;

    // most waiters a single wake may release
    localparam logic [4:0] WAKE_CAP = 5'd16;

endpackage

// ===== rtl/address_wait_wake_table_core.sv =====
// address wait/wake table: compact arrival-ordered waiter memory with scan controller
//
// channel | dir | tdata (low bit up)                                  | tuser       | tlast
// s_      | in  | space_id 8, word_addr 32, task_id 8, operand 32,    | action 2    | -
//         |     | current 32                                          |             |
// m_      | out | status 3, woken_task 8, woken_count 5               | task_valid  | last
//
// wait, fault, invalid and unsupported requests: result registered on accept, valid in the next cycle.
// wake (nonzero address, non-negative operand) and withdraw scan the table memory one entry per
// cycle while no wake result is stalled on the result side; the single read port sets this rate.
// kept entries are written back compacted behind the read pointer, so no hazard arises.
// reset clears only the fill count and control; no clearing pass over the memory.
// a new request is taken only in idle and while the output register is free or draining.
module address_wait_wake_table_core
    import awwt_pkg::*;
#(
    parameter int WAITER_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // space_id[7:0], word_addr[39:8], task_id[47:40], operand_value[79:48],
    // current_value[111:80]
    input  logic [111:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], woken_task[10:3], woken_count[15:11]
    output logic [15:0]  m_tdata,
    // task_valid[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int IW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int CW = $clog2(WAITER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WAITER_DEPTH);

    // waiter memory and its registered read port
    entry_t           mem [WAITER_DEPTH];
    entry_t           rd_data_reg;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    entry_t           wr_data;

    state_t           state_reg, state_next;
    logic [CW-1:0]    total_reg, total_next;
    logic [CW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    w_ptr_reg, w_ptr_next;
    logic             pend_reg, pend_next;
    logic             removed_reg, removed_next;
    logic [4:0]       woken_reg, woken_next;
    logic [4:0]       lim_reg, lim_next;
    logic             req_wake_reg, req_wake_next;
    entry_t           req_reg, req_next;

    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;
    logic             m_tv_reg, m_tv_next;
    logic [7:0]       m_task_reg, m_task_next;
    logic [4:0]       m_count_reg, m_count_next;
    logic             m_last_reg, m_last_next;

    // input field views
    action_t          in_action;
    logic [7:0]       in_space;
    logic [31:0]      in_addr;
    logic [7:0]       in_task;
    logic [31:0]      in_operand;
    logic [31:0]      in_current;

    logic             out_free;
    logic             in_acc;
    logic             scan_op;
    logic             hit;
    logic             emit;
    logic             advance;

    assign in_action  = action_t'(s_tuser);
    assign in_space   = s_tdata[7:0];
    assign in_addr    = s_tdata[39:8];
    assign in_task    = s_tdata[47:40];
    assign in_operand = s_tdata[79:48];
    assign in_current = s_tdata[111:80];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == FSM_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // requests that walk the table
    assign scan_op = (in_action == ACT_WITHDRAW) ||
                     ((in_action == ACT_WAKE) && (in_addr != 32'd0) && !in_operand[31]);

    // match test on the entry under evaluation
    always_comb begin
        if (req_wake_reg) begin
            hit = (rd_data_reg.space == req_reg.space) && (rd_data_reg.addr == req_reg.addr) &&
                  (woken_reg < lim_reg);
        end else begin
            hit = (rd_data_reg.task_id == req_reg.task_id) && !removed_reg;
        end
    end

    assign emit    = pend_reg && hit && req_wake_reg;
    assign advance = (state_reg == FSM_SCAN) && pend_reg && !(emit && !out_free);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_acc && scan_op) begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                if (!pend_reg) begin
                    state_next = FSM_FINAL;
                end
            end
            FSM_FINAL: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // datapath and result control
    always_comb begin
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = w_ptr_reg[IW-1:0];
        wr_data       = rd_data_reg;
        total_next    = total_reg;
        rd_ptr_next   = rd_ptr_reg;
        w_ptr_next    = w_ptr_reg;
        pend_next     = pend_reg;
        removed_next  = removed_reg;
        woken_next    = woken_reg;
        lim_next      = lim_reg;
        req_wake_next = req_wake_reg;
        req_next      = req_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_tv_next     = m_tv_reg;
        m_task_next   = m_task_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            FSM_IDLE: begin
                if (in_acc) begin
                    req_next.space   = in_space;
                    req_next.addr    = in_addr;
                    req_next.task_id = in_task;
                    req_wake_next    = (in_action == ACT_WAKE);
                    lim_next         = (in_operand > 32'd16) ? WAKE_CAP : in_operand[4:0];
                    woken_next       = 5'd0;
                    removed_next     = 1'b0;
                    // start the scan at entry zero
                    rd_en            = 1'b1;
                    rd_addr          = '0;
                    rd_ptr_next      = CW'(1);
                    w_ptr_next       = '0;
                    pend_next        = (total_reg != '0);
                    if (!scan_op) begin
                        m_valid_next  = 1'b1;
                        m_tv_next     = 1'b0;
                        m_task_next   = 8'd0;
                        m_count_next  = 5'd0;
                        m_last_next   = 1'b1;
                        m_status_next = ST_DONE;
                        if (in_addr == 32'd0) begin
                            m_status_next = ST_FAULT;
                        end else begin
                            unique case (in_action)
                                ACT_WAIT: begin
                                    if (in_current != in_operand) begin
                                        m_status_next = ST_AGAIN;
                                    end else if (total_reg == DEPTH_C) begin
                                        m_status_next = ST_FULL;
                                    end else begin
                                        wr_en         = 1'b1;
                                        wr_addr       = total_reg[IW-1:0];
                                        wr_data.space   = in_space;
                                        wr_data.addr    = in_addr;
                                        wr_data.task_id = in_task;
                                        total_next    = total_reg + CW'(1);
                                    end
                                end
                                ACT_WAKE:     m_status_next = ST_INVALID;
                                ACT_WITHDRAW: m_status_next = ST_DONE;
                                ACT_OTHER:    m_status_next = ST_UNSUPPORTED;
                                default:      m_status_next = ST_UNSUPPORTED;
                            endcase
                        end
                    end
                end
            end
            FSM_SCAN: begin
                if (advance) begin
                    if (hit) begin
                        // entry leaves the table
                        removed_next = 1'b1;
                        if (req_wake_reg) begin
                            woken_next    = woken_reg + 5'd1;
                            m_valid_next  = 1'b1;
                            m_status_next = ST_DONE;
                            m_tv_next     = 1'b1;
                            m_task_next   = rd_data_reg.task_id;
                            m_count_next  = woken_reg + 5'd1;
                            m_last_next   = 1'b0;
                        end
                    end else begin
                        // keep: compact into the write slot
                        wr_en      = 1'b1;
                        w_ptr_next = w_ptr_reg + CW'(1);
                    end
                    if (rd_ptr_reg < total_reg) begin
                        rd_en       = 1'b1;
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                    end else begin
                        pend_next = 1'b0;
                    end
                end
                if (!pend_reg) begin
                    total_next = w_ptr_reg;
                end
            end
            FSM_FINAL: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_tv_next     = 1'b0;
                    m_task_next   = 8'd0;
                    m_last_next   = 1'b1;
                    m_count_next  = req_wake_reg ? woken_reg : 5'd0;
                    m_status_next = (!req_wake_reg && removed_reg) ? ST_WITHDRAWN : ST_DONE;
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        w_ptr_reg    <= w_ptr_next;
        removed_reg  <= removed_next;
        woken_reg    <= woken_next;
        lim_reg      <= lim_next;
        req_wake_reg <= req_wake_next;
        req_reg      <= req_next;
        m_status_reg <= m_status_next;
        m_tv_reg     <= m_tv_next;
        m_task_reg   <= m_task_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_task_reg, m_status_reg};
    assign m_tuser  = m_tv_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // fill count stays within the table
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= DEPTH_C)
        else $error("waiter count exceeds table depth");

    // compaction write slot never passes the read pointer
    a_wptr_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SCAN) |-> (w_ptr_reg <= rd_ptr_reg &&
                                     (rd_ptr_reg <= total_reg || rd_ptr_reg == CW'(1))))
        else $error("compaction pointer ahead of read pointer");

    // a wake never releases more than its limit
    a_wake_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != FSM_IDLE && req_wake_reg) |-> (woken_reg <= lim_reg))
        else $error("wake released more waiters than allowed");

    // a woken-task result carries a count and is never the final one
    a_woken_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[15:11] != 5'd0 && !m_tlast))
        else $error("woken-task result malformed");

    // scan ends with the table shrunk to the kept entries
    a_scan_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_SCAN && !pend_reg) |=> (total_reg == $past(w_ptr_reg)))
        else $error("fill count not updated after scan");
`endif

endmodule
